@@ hw/rtl/fra_pkg.sv @@
// Shared constants for the fenced ring allocator.
package fra_pkg;

    localparam int STAMP_W = 64;
    localparam int ALIGN_W = 5;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RECLAIM = 1'b1;

endpackage

@@ hw/rtl/fenced_ring_allocator.sv @@
// Top level of the fenced ring allocator: control, state registers and region FIFO.
//
// Usage: an item is taken when start is high while busy is low. An item is
// either an allocate (op 0: req_size, align_log2, expiry stamp) or a reclaim
// (op 1: current stamp). Each item produces exactly one result word, shown on
// the o_ result ports for a single cycle while o_valid is high. The receiver
// must take it in that cycle; there is no stall on the result side.
// An allocate goes from acceptance to its result in these steps: the item is
// registered, the placement unit forms and registers room and padding, and the
// commit state writes the region FIFO memory. Busy falls as the result appears,
// so a new allocate is taken only once the previous result is shown.
// A reclaim on a non-empty FIFO reads the head region, then checks it and, while
// regions have expired, frees one per cycle and reads the next, stopping when the
// FIFO empties or at an unexpired region; an empty FIFO needs no memory read.
// The user must write the capacity register through i_cfg_we and i_cfg_wdata only
// while the block is idle; the block does not enforce this. Synchronous active-low
// reset clears the ring positions, the used count and the FIFO pointers and sets
// capacity to 2^ADDR_BITS; the region memory is not cleared.
module fenced_ring_allocator import fra_pkg::*; #(
    parameter int ADDR_BITS    = 24,
    parameter int REGION_DEPTH = 64,
    localparam int PW          = ADDR_BITS + 1,
    localparam int FREED_W     = $clog2(REGION_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [ADDR_BITS-1:0] i_req_size,
    input  logic [ALIGN_W-1:0]   i_align_log2,
    input  logic [STAMP_W-1:0]   i_frame_stamp,
    input  logic                 i_cfg_we,
    input  logic [PW-1:0]        i_cfg_wdata,
    output logic                 o_valid,
    output logic                 o_granted,
    output logic [ADDR_BITS-1:0] o_region_offset,
    output logic [FREED_W-1:0]   o_freed_regions,
    output logic [PW-1:0]        o_used_total
);

    localparam int IW = $clog2(REGION_DEPTH);
    localparam int CW = $clog2(REGION_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = STAMP_W + ADDR_BITS + PW;
    localparam logic [PW-1:0] CAP_RESET = PW'(1) << ADDR_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT,
        S_COMMIT,
        S_RECL_RD,
        S_RECL_CHK
    } t_state;

    t_state               r_state, n_state;
    logic [PW-1:0]        r_cap, n_cap;
    logic [PW-1:0]        r_wpos, n_wpos;
    logic [PW-1:0]        r_bpos, n_bpos;
    logic [PW-1:0]        r_used, n_used;
    logic [IW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [FREED_W-1:0]   r_freed, n_freed;
    logic                 r_valid, n_valid;
    logic                 r_granted, n_granted;
    logic [ADDR_BITS-1:0] r_offset, n_offset;
    logic [FREED_W-1:0]   r_out_freed, n_out_freed;
    logic [PW-1:0]        r_out_used, n_out_used;

    logic                 r_op, n_op;
    logic [ADDR_BITS-1:0] r_size, n_size;
    logic [ALIGN_W-1:0]   r_align, n_align;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;

    logic                 fit_load;
    logic                 fit_ok;
    logic [PW-1:0]        fit_at;
    logic [PW-1:0]        fit_stop;
    logic                 fifo_full;
    logic [SW-1:0]        tail_sum;
    logic [IW-1:0]        tail;
    logic [IW-1:0]        head_next;

    logic                 mem_wr_en;
    logic [EW-1:0]        mem_wr_data;
    logic                 mem_rd_en;
    logic [IW-1:0]        mem_rd_addr;
    logic [EW-1:0]        mem_rd_data;
    logic [STAMP_W-1:0]   rd_expiry;
    logic [ADDR_BITS-1:0] rd_start;
    logic [PW-1:0]        rd_stop;
    logic [PW-1:0]        pop_len;

    fra_fit #(
        .ADDR_BITS(ADDR_BITS)
    ) u_fra_fit (
        .i_clk       (i_clk),
        .i_load      (fit_load),
        .i_cap       (r_cap),
        .i_write_pos (r_wpos),
        .i_begin_pos (r_bpos),
        .i_used      (r_used),
        .i_size      (r_size),
        .i_align     (r_align),
        .i_full      (fifo_full),
        .o_ok        (fit_ok),
        .o_at        (fit_at)
    );

    fra_region_mem #(
        .DATA_W(EW),
        .DEPTH (REGION_DEPTH)
    ) u_fra_region_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (tail),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        fit_load    = (r_state == S_FIT);
        fifo_full   = (r_count == CW'(REGION_DEPTH));
        tail_sum    = SW'(r_head) + SW'(r_count);
        tail        = (tail_sum >= SW'(REGION_DEPTH))
                      ? IW'(tail_sum - SW'(REGION_DEPTH)) : IW'(tail_sum);
        head_next   = (r_head == IW'(REGION_DEPTH - 1)) ? '0 : (r_head + IW'(1));
        fit_stop    = fit_at + PW'(r_size);
        mem_wr_data = {r_stamp, fit_at[ADDR_BITS-1:0], fit_stop};
        rd_expiry   = mem_rd_data[EW-1 -: STAMP_W];
        rd_start    = mem_rd_data[PW +: ADDR_BITS];
        rd_stop     = mem_rd_data[PW-1:0];
        pop_len     = (rd_stop >= PW'(rd_start)) ? (rd_stop - PW'(rd_start)) : '0;
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = i_cfg_we ? i_cfg_wdata : r_cap;
        n_wpos      = r_wpos;
        n_bpos      = r_bpos;
        n_used      = r_used;
        n_head      = r_head;
        n_count     = r_count;
        n_freed     = r_freed;
        n_valid     = 1'b0;
        n_granted   = r_granted;
        n_offset    = r_offset;
        n_out_freed = r_out_freed;
        n_out_used  = r_out_used;
        n_op        = r_op;
        n_size      = r_size;
        n_align     = r_align;
        n_stamp     = r_stamp;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_op;
                    n_size  = i_req_size;
                    n_align = i_align_log2;
                    n_stamp = i_frame_stamp;
                    n_freed = '0;
                    n_state = (i_op == OP_RECLAIM) ? S_RECL_RD : S_FIT;
                end
            end
            S_FIT: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (fit_ok) begin
                    mem_wr_en = 1'b1;
                    n_count   = r_count + CW'(1);
                    n_used    = r_used + PW'(r_size);
                    n_wpos    = fit_stop;
                end
                n_valid     = 1'b1;
                n_granted   = fit_ok;
                n_offset    = fit_ok ? fit_at[ADDR_BITS-1:0] : '0;
                n_out_freed = '0;
                n_out_used  = n_used;
                n_state     = S_IDLE;
            end
            S_RECL_RD: begin
                if (r_count == '0) begin
                    n_valid     = 1'b1;
                    n_granted   = 1'b1;
                    n_offset    = '0;
                    n_out_freed = r_freed;
                    n_out_used  = r_used;
                    n_state     = S_IDLE;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = S_RECL_CHK;
                end
            end
            S_RECL_CHK: begin
                if (rd_expiry > r_stamp) begin
                    n_valid     = 1'b1;
                    n_granted   = 1'b1;
                    n_offset    = '0;
                    n_out_freed = r_freed;
                    n_out_used  = r_used;
                    n_state     = S_IDLE;
                end else begin
                    n_bpos  = rd_stop;
                    n_used  = (r_used >= pop_len) ? (r_used - pop_len) : '0;
                    n_head  = head_next;
                    n_count = r_count - CW'(1);
                    n_freed = r_freed + FREED_W'(1);
                    if (r_count == CW'(1)) begin
                        n_valid     = 1'b1;
                        n_granted   = 1'b1;
                        n_offset    = '0;
                        n_out_freed = n_freed;
                        n_out_used  = n_used;
                        n_state     = S_IDLE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_wpos  <= '0;
            r_bpos  <= '0;
            r_used  <= '0;
            r_head  <= '0;
            r_count <= '0;
            r_freed <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_wpos      <= n_wpos;
            r_bpos      <= n_bpos;
            r_used      <= n_used;
            r_head      <= n_head;
            r_count     <= n_count;
            r_freed     <= n_freed;
            r_valid     <= n_valid;
            r_granted   <= n_granted;
            r_offset    <= n_offset;
            r_out_freed <= n_out_freed;
            r_out_used  <= n_out_used;
            r_op        <= n_op;
            r_size      <= n_size;
            r_align     <= n_align;
            r_stamp     <= n_stamp;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_granted       = r_granted;
    assign o_region_offset = r_offset;
    assign o_freed_regions = r_out_freed;
    assign o_used_total    = r_out_used;

endmodule

@@ hw/rtl/fra_region_mem.sv @@
// Region FIFO storage: one synchronous memory with a registered read port.
module fra_region_mem #(
    parameter int DATA_W = 113,
    parameter int DEPTH  = 64,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/fra_fit.sv @@
// Placement unit: registered room and padding, then the fit decision.
module fra_fit import fra_pkg::*; #(
    parameter int ADDR_BITS = 24,
    localparam int PW       = ADDR_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [PW-1:0]        i_cap,
    input  logic [PW-1:0]        i_write_pos,
    input  logic [PW-1:0]        i_begin_pos,
    input  logic [PW-1:0]        i_used,
    input  logic [ADDR_BITS-1:0] i_size,
    input  logic [ALIGN_W-1:0]   i_align,
    input  logic                 i_full,
    output logic                 o_ok,
    output logic [PW-1:0]        o_at
);

    localparam int XW = (PW > 32 ? PW : 32) + 1;
    localparam logic [PW-1:0] CAP_MAX = PW'(1) << ADDR_BITS;

    logic [PW-1:0] cap_eff;
    logic          unwrapped;
    logic [PW-1:0] room;
    logic [XW-1:0] mask;
    logic [XW-1:0] pad;

    logic          r_pre_ok;
    logic          r_unwrapped;
    logic          r_wrap_fit;
    logic [XW-1:0] r_room;
    logic [XW-1:0] r_pad;
    logic [XW-1:0] r_size;
    logic [XW-1:0] r_write_pos;

    logic          fits;
    logic [XW-1:0] placed;

    always_comb begin
        cap_eff   = (i_cap > CAP_MAX) ? CAP_MAX : i_cap;
        unwrapped = (i_begin_pos < i_write_pos)
                    || ((i_begin_pos == i_write_pos) && (i_used == '0));
        if (unwrapped) begin
            room = (i_write_pos < cap_eff) ? (cap_eff - i_write_pos) : '0;
        end else begin
            room = i_begin_pos - i_write_pos;
        end
        mask = (XW'(1) << i_align) - XW'(1);
        pad  = (XW'(0) - XW'(i_write_pos)) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pre_ok    <= (PW'(i_size) < cap_eff) && !i_full;
            r_unwrapped <= unwrapped;
            r_wrap_fit  <= (PW'(i_size) <= i_begin_pos);
            r_room      <= XW'(room);
            r_pad       <= pad;
            r_size      <= XW'(i_size);
            r_write_pos <= XW'(i_write_pos);
        end
    end

    always_comb begin
        fits   = (r_room >= r_pad) && ((r_room - r_pad) >= r_size);
        placed = r_write_pos + r_pad;
        o_ok   = r_pre_ok && (fits || (r_unwrapped && r_wrap_fit));
        o_at   = fits ? placed[PW-1:0] : '0;
    end

endmodule

@@ hw/rtl/fra_checker.sv @@
// Port-level checks for the fenced ring allocator and their binding.
module fra_checker #(
    parameter int ADDR_BITS = 24,
    parameter int FREED_W   = 7
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic                 o_granted,
    input logic [ADDR_BITS-1:0] o_region_offset,
    input logic [FREED_W-1:0]   o_freed_regions
);

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted word did not raise busy.");

    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result word shown while still busy.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("Result word without preceding work.");

    a_refused_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_region_offset == '0))
        else $error("Refused allocation carries a nonzero offset.");

    a_freed_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_freed_regions != '0)) |-> o_granted)
        else $error("Freed regions reported on a refused word.");

endmodule

bind fenced_ring_allocator fra_checker #(
    .ADDR_BITS(ADDR_BITS),
    .FREED_W  (FREED_W)
) u_fra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_granted       (o_granted),
    .o_region_offset (o_region_offset),
    .o_freed_regions (o_freed_regions)
);

@@ test/tb_fenced_ring_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fenced ring allocator with a ring ledger scoreboard.

localparam int RING_ADDR_W = 24;
localparam int RING_SLOTS = 64;
localparam bit [63:0] RING_SPAN = 64'd1 << RING_ADDR_W;
localparam bit [63:0] MASK_OFFSET = 64'hFF_FFFF;
localparam bit [63:0] MASK_POS = 64'h1FF_FFFF;

typedef struct {
    bit        granted;
    bit [23:0] offset;
    bit [6:0]  freed;
    bit [24:0] used;
} result_word_t;

class region_ledger;
    bit [63:0] capacity = RING_SPAN;
    bit [63:0] write_pos = 0;
    bit [63:0] begin_pos = 0;
    bit [63:0] used_bytes = 0;
    bit [63:0] expiry [RING_SLOTS];
    bit [63:0] start_at [RING_SLOTS];
    bit [63:0] stop_at [RING_SLOTS];
    int unsigned head = 0;
    int unsigned count = 0;
    result_word_t awaited [$];
    int unsigned errors = 0;
    int unsigned grants = 0;
    int unsigned refusals = 0;
    int unsigned reclaims = 0;
    int unsigned regions_freed = 0;

    function bit [64:0] place_aligned(bit [4:0] al, bit [63:0] sz, bit [63:0] pos,
                                      bit [63:0] room);
        bit [63:0] align;
        bit [63:0] pad;
        align = 64'd1 << al;
        pad = pos & (align - 64'd1);
        if (pad != 0) begin
            pad = align - pad;
        end
        if (room < pad || room - pad < sz) begin
            return {1'b0, 64'd0};
        end
        return {1'b1, pos + pad};
    endfunction

    function void note_request(bit op, bit [23:0] size, bit [4:0] al, bit [63:0] stamp);
        result_word_t w;
        bit [63:0] cap;
        bit [63:0] at;
        bit [63:0] len;
        bit [64:0] fit;
        bit ok;
        bit halt;
        int unsigned slot;
        w.granted = 1'b0;
        w.offset = '0;
        w.freed = '0;
        if (op == fra_pkg::OP_ALLOC) begin
            cap = (capacity > RING_SPAN) ? RING_SPAN : capacity;
            ok = (size < cap) && (count < RING_SLOTS);
            at = 0;
            if (ok) begin
                if (begin_pos < write_pos || (begin_pos == write_pos && used_bytes == 0)) begin
                    fit = place_aligned(al, size, write_pos,
                                        (write_pos < cap) ? cap - write_pos : 64'd0);
                    if (fit[64]) begin
                        at = fit[63:0];
                    end else if (size > begin_pos) begin
                        ok = 1'b0;
                    end
                end else begin
                    fit = place_aligned(al, size, write_pos, begin_pos - write_pos);
                    ok = fit[64];
                    at = fit[63:0];
                end
            end
            if (ok) begin
                slot = (head + count) % RING_SLOTS;
                expiry[slot] = stamp;
                start_at[slot] = at & MASK_OFFSET;
                stop_at[slot] = (at + size) & MASK_POS;
                count++;
                used_bytes = (used_bytes + size) & MASK_POS;
                write_pos = (at + size) & MASK_POS;
                w.granted = 1'b1;
                w.offset = at[23:0];
                grants++;
            end else begin
                refusals++;
            end
        end else begin
            w.granted = 1'b1;
            halt = 1'b0;
            reclaims++;
            while (count > 0 && !halt) begin
                if (expiry[head] > stamp) begin
                    halt = 1'b1;
                end else begin
                    begin_pos = stop_at[head];
                    len = (stop_at[head] >= start_at[head]) ? stop_at[head] - start_at[head] : 0;
                    used_bytes = (used_bytes >= len) ? used_bytes - len : 64'd0;
                    head = (head + 1) % RING_SLOTS;
                    count--;
                    w.freed++;
                    regions_freed++;
                end
            end
        end
        w.used = used_bytes[24:0];
        awaited.push_back(w);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_word(logic granted, logic [23:0] offset, logic [6:0] freed,
                             logic [24:0] used);
        result_word_t w;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got granted %0d offset %0d",
                     $time, granted, offset);
            errors++;
            return;
        end
        w = awaited.pop_front();
        compare_field("granted", w.granted, granted);
        compare_field("region_offset", w.offset, offset);
        compare_field("freed_regions", w.freed, freed);
        compare_field("used_total", w.used, used);
    endfunction
endclass

module tb;
    import fra_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [23:0] i_req_size;
    logic [4:0]  i_align_log2;
    logic [63:0] i_frame_stamp;
    logic        i_cfg_we;
    logic [24:0] i_cfg_wdata;
    logic        o_valid;
    logic        o_granted;
    logic [23:0] o_region_offset;
    logic [6:0]  o_freed_regions;
    logic [24:0] o_used_total;

    region_ledger ledger = new();
    bit [63:0] frame_now = 64'd100;
    int unsigned burst_left = 0;
    int unsigned settings_used = 0;
    longint unsigned cycles = 0;

    fenced_ring_allocator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_req_size(i_req_size),
        .i_align_log2(i_align_log2),
        .i_frame_stamp(i_frame_stamp),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid),
        .o_granted(o_granted),
        .o_region_offset(o_region_offset),
        .o_freed_regions(o_freed_regions),
        .o_used_total(o_used_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("fenced_ring_allocator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            ledger.check_word(o_granted, o_region_offset, o_freed_regions, o_used_total);
        end
    end

    task automatic send_item(logic op, logic [23:0] size, logic [4:0] al, logic [63:0] stamp);
        @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_req_size <= size;
        i_align_log2 <= al;
        i_frame_stamp <= stamp;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        ledger.note_request(op, size, al, stamp);
    endtask

    task automatic hold_off(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_op <= 1'($urandom);
            i_req_size <= 24'($urandom);
            i_align_log2 <= 5'($urandom);
            i_frame_stamp <= {$urandom, $urandom};
        end
    endtask

    task automatic paced_item(logic op, logic [23:0] size, logic [4:0] al, logic [63:0] stamp);
        if (burst_left == 0) begin
            hold_off($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        send_item(op, size, al, stamp);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.awaited.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [24:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.capacity = value;
        settings_used++;
        burst_left = 0;
    endtask

    task automatic random_item(int unsigned max_size);
        logic [23:0] size;
        logic [4:0] al;
        logic [63:0] stamp;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            if (pick < 3) begin
                stamp = '1;
            end else if (pick < 5) begin
                stamp = {$urandom, $urandom};
            end else begin
                stamp = frame_now;
                frame_now += $urandom_range(0, 3);
            end
            paced_item(OP_RECLAIM, 24'($urandom), 5'($urandom), stamp);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                size = 24'($urandom_range(0, max_size / 4));
            end else if (pick < 92) begin
                size = 24'($urandom_range(0, max_size));
            end else begin
                size = 24'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                al = 5'($urandom_range(0, 4));
            end else if (pick < 95) begin
                al = 5'($urandom_range(5, 16));
            end else begin
                al = 5'($urandom_range(17, 31));
            end
            if ($urandom_range(0, 39) == 0) begin
                stamp = {$urandom, $urandom};
            end else begin
                stamp = frame_now + $urandom_range(0, 6);
            end
            paced_item(OP_ALLOC, size, al, stamp);
        end
    endtask

    task automatic run_phase(logic [24:0] cap, int unsigned n, int unsigned max_size);
        set_capacity(cap);
        repeat (n) random_item(max_size);
    endtask

    initial begin
        int unsigned cap_pick;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_ALLOC;
        i_req_size = '0;
        i_align_log2 = '0;
        i_frame_stamp = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_capacity(25'd16777216);
        paced_item(OP_ALLOC, 24'd0, 5'd0, 64'd0);
        paced_item(OP_ALLOC, 24'hFFFFFF, 5'd0, 64'd1);
        paced_item(OP_ALLOC, 24'hFFFFFF, 5'd0, 64'd1);
        paced_item(OP_ALLOC, 24'd1, 5'd0, 64'd2);
        paced_item(OP_ALLOC, 24'd0, 5'd31, 64'd3);
        paced_item(OP_RECLAIM, 24'd0, 5'd0, 64'd0);
        paced_item(OP_RECLAIM, 24'hFFFFFF, 5'h1F, '1);
        paced_item(OP_ALLOC, 24'd100, 5'd16, 64'd10);
        paced_item(OP_ALLOC, 24'd5, 5'd16, 64'd10);
        paced_item(OP_ALLOC, 24'd7, 5'd3, 64'd11);
        paced_item(OP_ALLOC, 24'h800000, 5'd0, 64'd12);
        paced_item(OP_ALLOC, 24'h7F0000, 5'd4, 64'd12);
        paced_item(OP_RECLAIM, 24'd0, 5'd0, 64'd10);
        paced_item(OP_ALLOC, 24'h00FFFF, 5'd0, 64'd20);
        paced_item(OP_ALLOC, 24'hFFFFFF, 5'd0, 64'd20);
        paced_item(OP_RECLAIM, 24'd0, 5'd0, 64'h8000_0000_0000_0000);
        paced_item(OP_ALLOC, 24'd0, 5'd17, '1);
        paced_item(OP_RECLAIM, 24'd0, 5'd0, '1);

        set_capacity(25'h1FFFFFF);
        repeat (RING_SLOTS + 3) begin
            paced_item(OP_ALLOC, 24'($urandom_range(0, 64)), 5'd0,
                       64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(0, 7));
        end
        paced_item(OP_RECLAIM, 24'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFF8);
        repeat (30) random_item(1 << 24);

        run_phase(25'd0, 8, 4);
        run_phase(25'd1, 20, 2);
        run_phase(25'd256, 80, 64);
        run_phase(25'd4096, 70, 1024);
        paced_item(OP_RECLAIM, 24'd0, 5'd0, '1);
        paced_item(OP_ALLOC, 24'd3000, 5'd0, frame_now + 64'd2);
        run_phase(25'd1000, 80, 250);
        cap_pick = $urandom_range(1, 1 << 24);
        run_phase(25'(cap_pick), 50, cap_pick);
        run_phase(25'd16777216, 40, 1 << 24);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (ledger.awaited.size() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time,
                     ledger.awaited.size());
            ledger.errors++;
        end
        $display("Ran %0d words over %0d capacity settings: %0d allocations granted, %0d refused.",
                 ledger.grants + ledger.refusals + ledger.reclaims, settings_used,
                 ledger.grants, ledger.refusals);
        $display("%0d reclaim words released %0d regions in all.", ledger.reclaims,
                 ledger.regions_freed);
        if (ledger.errors == 0) begin
            $display("fenced_ring_allocator regression: pass");
        end else begin
            $display("fenced_ring_allocator regression: fail");
        end
        $finish;
    end
endmodule
